// File: design/ozh_pkg.sv
// Shared types, constants and helper functions for the obstacle zone classifier.
// No dependencies; every other design file depends on this package.
package ozh_pkg;

   // Field widths
   localparam int unsigned DEPTH_W    = 16;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned SAFE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned ZONE_W     = 2;

   // Fixed pixel count minimums for a region to count as an obstacle
   localparam logic [COUNT_W-1:0] NEAR_COUNT_MIN  = 16'd4;
   localparam logic [COUNT_W-1:0] VALID_PIXEL_MIN = 16'd60;

   // Result zone codes
   typedef logic [ZONE_W-1:0] zone_code_type;
   localparam zone_code_type ZONE_CLEAR  = 2'd0;
   localparam zone_code_type ZONE_LEFT   = 2'd1;
   localparam zone_code_type ZONE_RIGHT  = 2'd2;
   localparam zone_code_type ZONE_CORNER = 2'd3;

   // Zone state machine, one-hot
   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_LEFT   = 4'b0010,
      ST_RIGHT  = 4'b0100,
      ST_CORNER = 4'b1000
   } zone_state_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRONT_ENTER = 3'd0,
      CSR_FRONT_EXIT  = 3'd1,
      CSR_EMERGENCY   = 3'd2,
      CSR_LEFT_ENTER  = 3'd3,
      CSR_LEFT_EXIT   = 3'd4,
      CSR_RIGHT_ENTER = 3'd5,
      CSR_RIGHT_EXIT  = 3'd6,
      CSR_SAFE_NEEDED = 3'd7
   } csr_idx_type;

   // Reset values of the configuration registers
   localparam logic [DEPTH_W-1:0] RST_ENTER_MM     = 16'd600;
   localparam logic [DEPTH_W-1:0] RST_EXIT_MM      = 16'd800;
   localparam logic [DEPTH_W-1:0] RST_EMERGENCY_MM = 16'd300;
   localparam logic [SAFE_W-1:0]  RST_SAFE_NEEDED  = 8'd5;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [COUNT_W-1:0] near_px;
      logic [COUNT_W-1:0] valid_px;
   } region_type;

   typedef struct packed {
      region_type front;
      region_type left;
      region_type right;
   } frame_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] front_enter;
      logic [DEPTH_W-1:0] front_exit;
      logic [DEPTH_W-1:0] emergency;
      logic [DEPTH_W-1:0] left_enter;
      logic [DEPTH_W-1:0] left_exit;
      logic [DEPTH_W-1:0] right_enter;
      logic [DEPTH_W-1:0] right_exit;
      logic [SAFE_W-1:0]  safe_needed;
   } cfg_type;

   // A region is an obstacle when it has depth, enough valid and near pixels,
   // and its depth lies below the threshold
   function automatic logic is_obstacle(region_type reg_i, logic [DEPTH_W-1:0] thresh);
      return (reg_i.depth != '0) && (reg_i.valid_px >= VALID_PIXEL_MIN) &&
             (reg_i.depth < thresh) && (reg_i.near_px >= NEAR_COUNT_MIN);
   endfunction

   function automatic zone_code_type zone_code(zone_state_type st);
      zone_code_type code;
      case (st)
         ST_CLEAR:  code = ZONE_CLEAR;
         ST_LEFT:   code = ZONE_LEFT;
         ST_RIGHT:  code = ZONE_RIGHT;
         ST_CORNER: code = ZONE_CORNER;
         default:   code = ZONE_CLEAR;
      endcase
      return code;
   endfunction

endpackage

// File: design/ozh_channel_if.sv
// Valid/ready channel interfaces: depth frame requests, zone responses, register writes.
// Depends on ozh_pkg for field widths.
interface ozh_req_if;
   logic                         valid;
   logic                         ready;
   logic [ozh_pkg::DEPTH_W-1:0]  front_depth;
   logic [ozh_pkg::COUNT_W-1:0]  front_near;
   logic [ozh_pkg::COUNT_W-1:0]  front_valid;
   logic [ozh_pkg::DEPTH_W-1:0]  left_depth;
   logic [ozh_pkg::COUNT_W-1:0]  left_near;
   logic [ozh_pkg::COUNT_W-1:0]  left_valid;
   logic [ozh_pkg::DEPTH_W-1:0]  right_depth;
   logic [ozh_pkg::COUNT_W-1:0]  right_near;
   logic [ozh_pkg::COUNT_W-1:0]  right_valid;

   modport source (output valid, front_depth, front_near, front_valid, left_depth,
                   left_near, left_valid, right_depth, right_near, right_valid,
                   input ready);
   modport sink (input valid, front_depth, front_near, front_valid, left_depth,
                 left_near, left_valid, right_depth, right_near, right_valid,
                 output ready);
endinterface

interface ozh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ozh_pkg::ZONE_W-1:0]  zone;

   modport source (output valid, zone, input ready);
   modport sink (input valid, zone, output ready);
endinterface

interface ozh_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ozh_pkg::CSR_IDX_W-1:0]   index;
   logic [ozh_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/ozh_csr.sv
// Configuration register file for the zone thresholds and the safe frame count.
// Depends on ozh_pkg and ozh_csr_if.
module ozh_csr (
   input  logic             clock,
   input  logic             reset,
   ozh_csr_if.sink          csr_ch,
   output ozh_pkg::cfg_type cfg
);
   import ozh_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // Decode the register index of a write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_FRONT_ENTER: cfg_in.front_enter = csr_ch.data;
            CSR_FRONT_EXIT:  cfg_in.front_exit  = csr_ch.data;
            CSR_EMERGENCY:   cfg_in.emergency   = csr_ch.data;
            CSR_LEFT_ENTER:  cfg_in.left_enter  = csr_ch.data;
            CSR_LEFT_EXIT:   cfg_in.left_exit   = csr_ch.data;
            CSR_RIGHT_ENTER: cfg_in.right_enter = csr_ch.data;
            CSR_RIGHT_EXIT:  cfg_in.right_exit  = csr_ch.data;
            CSR_SAFE_NEEDED: cfg_in.safe_needed = csr_ch.data[SAFE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_enter <= RST_ENTER_MM;
         cfg_ff.front_exit  <= RST_EXIT_MM;
         cfg_ff.emergency   <= RST_EMERGENCY_MM;
         cfg_ff.left_enter  <= RST_ENTER_MM;
         cfg_ff.left_exit   <= RST_EXIT_MM;
         cfg_ff.right_enter <= RST_ENTER_MM;
         cfg_ff.right_exit  <= RST_EXIT_MM;
         cfg_ff.safe_needed <= RST_SAFE_NEEDED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/ozh_zone_core.sv
// Zone decision with hysteresis: emergency, exit and enter rules, safe frame counter.
// Depends on ozh_pkg; holds the zone state and safe count registers.
module ozh_zone_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ozh_pkg::frame_type     frame,
   input  ozh_pkg::cfg_type       cfg,
   output ozh_pkg::zone_code_type zone_next
);
   import ozh_pkg::*;

   zone_state_type     zone_state_ff, zone_state_in;
   logic [SAFE_W-1:0]  safe_count_ff, safe_count_in;
   logic [SAFE_W-1:0]  safe_need;
   logic [SAFE_W-1:0]  safe_inc;
   logic               front_em;
   logic               front_ex, left_ex, right_ex;
   logic               front_en, left_en, right_en;

   // Region tests against every threshold
   assign front_em = is_obstacle(frame.front, cfg.emergency);
   assign front_ex = is_obstacle(frame.front, cfg.front_exit);
   assign left_ex  = is_obstacle(frame.left, cfg.left_exit);
   assign right_ex = is_obstacle(frame.right, cfg.right_exit);
   assign front_en = is_obstacle(frame.front, cfg.front_enter);
   assign left_en  = is_obstacle(frame.left, cfg.left_enter);
   assign right_en = is_obstacle(frame.right, cfg.right_enter);

   // A zero requirement acts as one; the counter saturates
   assign safe_need = (cfg.safe_needed == '0) ? SAFE_W'(1) : cfg.safe_needed;
   assign safe_inc  = (&safe_count_ff) ? safe_count_ff : safe_count_ff + SAFE_W'(1);

   // Next zone and safe count
   always_comb begin
      zone_state_in = zone_state_ff;
      safe_count_in = safe_count_ff;
      if (front_em) begin
         zone_state_in = ST_CORNER;
         safe_count_in = '0;
      end else if (zone_state_ff != ST_CLEAR) begin
         if (front_ex || left_ex || right_ex) begin
            safe_count_in = '0;
            if (front_ex) begin
               zone_state_in = ST_CORNER;
            end else if (left_ex && !right_ex) begin
               zone_state_in = ST_LEFT;
            end else if (right_ex && !left_ex) begin
               zone_state_in = ST_RIGHT;
            end else begin
               // both sides: nearer wins, ties go left
               zone_state_in = (frame.left.depth <= frame.right.depth) ? ST_LEFT : ST_RIGHT;
            end
         end else if (safe_inc >= safe_need) begin
            zone_state_in = ST_CLEAR;
            safe_count_in = '0;
         end else begin
            safe_count_in = safe_inc;
         end
      end else begin
         if (front_en) begin
            zone_state_in = ST_CORNER;
            safe_count_in = '0;
         end else if (left_en) begin
            zone_state_in = ST_LEFT;
            safe_count_in = '0;
         end else if (right_en) begin
            zone_state_in = ST_RIGHT;
            safe_count_in = '0;
         end
      end
   end

   assign zone_next = zone_code(zone_state_in);

   // Commit state only when the frame moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_state_ff <= ST_CLEAR;
         safe_count_ff <= '0;
      end else if (advance) begin
         zone_state_ff <= zone_state_in;
         safe_count_ff <= safe_count_in;
      end
   end

   a_clear_no_count: assert property (@(posedge clock) disable iff (reset)
      (zone_state_ff == ST_CLEAR) |-> (safe_count_ff == '0))
      else $error("safe count nonzero while zone is clear");

   a_emergency_corner: assert property (@(posedge clock) disable iff (reset)
      (advance && front_em) |=> (zone_state_ff == ST_CORNER) && (safe_count_ff == '0))
      else $error("emergency frame did not force corner");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(zone_state_ff) && $stable(safe_count_ff))
      else $error("zone state changed without a frame advancing");

endmodule

// File: design/obstacle_zone_hysteresis_top.sv
// Path: a frame accepted into the input register moves to the result register when that is free or drained.
// Throughput: one frame per cycle while rsp_ch is ready; the input register refills while the result is taken.
// The only feedback path is the zone state and safe count update in the zone core.
// Reset: synchronous, active high; zone clear, safe count zero, configuration registers at defaults.
// Top level: input register, zone core, result register and configuration registers.
// Depends on ozh_pkg, the channel interfaces, ozh_csr and ozh_zone_core.
module obstacle_zone_hysteresis_top (
   input  logic      clock,
   input  logic      reset,
   ozh_req_if.sink   req_ch,
   ozh_rsp_if.source rsp_ch,
   ozh_csr_if.sink   csr_ch
);
   import ozh_pkg::*;

   cfg_type       cfg;
   frame_type     frame_ff, frame_in;
   logic          in_valid_ff, in_valid_in;
   logic          out_valid_ff, out_valid_in;
   zone_code_type zone_ff, zone_next;
   logic          req_beat;
   logic          advance;

   ozh_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ozh_zone_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .frame     (frame_ff),
      .cfg       (cfg),
      .zone_next (zone_next)
   );

   // Advance when the result register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_beat     = req_ch.valid && req_ch.ready;

   assign frame_in.front.depth    = req_ch.front_depth;
   assign frame_in.front.near_px  = req_ch.front_near;
   assign frame_in.front.valid_px = req_ch.front_valid;
   assign frame_in.left.depth     = req_ch.left_depth;
   assign frame_in.left.near_px   = req_ch.left_near;
   assign frame_in.left.valid_px  = req_ch.left_valid;
   assign frame_in.right.depth    = req_ch.right_depth;
   assign frame_in.right.near_px  = req_ch.right_near;
   assign frame_in.right.valid_px = req_ch.right_valid;

   // Input and result occupancy
   assign in_valid_in  = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_beat) begin
         frame_ff <= frame_in;
      end
      if (advance) begin
         zone_ff <= zone_next;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.zone  = zone_ff;

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff && (zone_ff == $past(zone_next)))
      else $error("advanced frame did not reach the result register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> rsp_ch.valid && $stable(rsp_ch.zone))
      else $error("waiting zone beat changed or dropped");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("empty input register refused a frame");

endmodule

// File: dv/obstacle_zone_hysteresis_top_tb.sv
// Self-checking bench for obstacle_zone_hysteresis_top: random depth frames, register phases.
// Depends on ozh_pkg and the channel interfaces; checks each zone beat against a local tracker.
`timescale 1ns / 100ps

module obstacle_zone_hysteresis_top_tb;
   import ozh_pkg::*;

   logic clock;
   logic reset;

   ozh_req_if req_ch();
   ozh_rsp_if rsp_ch();
   ozh_csr_if csr_ch();

   obstacle_zone_hysteresis_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Tracked copy of the block: registers, zone and safe frame count
   cfg_type       zone_cfg;
   zone_code_type tracked_zone;
   logic [7:0]    tracked_safe;

   frame_type     pending_frames[$];
   zone_code_type expected_zones[$];
   int            frames_in_flight = 0;
   int            mismatch_count   = 0;

   int send_gap;
   int sink_wait;
   int src_run    = 0;
   bit src_quiet  = 1'b0;
   int sink_run   = 0;
   bit sink_quiet = 1'b0;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(string what);
      $display("[%0t] zone mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Wait per beat: runs of zero waits and runs of random waits, the kind drawn at random for each run
   function automatic int draw_wait(ref int run_left, ref bit quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 40);
         quiet    = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic bit region_blocks(region_type r, logic [15:0] limit);
      return (r.depth != 16'd0) && (r.depth < limit) &&
             (r.valid_px >= VALID_PIXEL_MIN) && (r.near_px >= NEAR_COUNT_MIN);
   endfunction

   // Advance the tracked zone by one frame and return the zone it reports
   function automatic zone_code_type next_zone(frame_type f);
      bit         front_hit;
      bit         left_hit;
      bit         right_hit;
      logic [7:0] need;
      if (region_blocks(f.front, zone_cfg.emergency)) begin
         tracked_zone = ZONE_CORNER;
         tracked_safe = 8'd0;
      end else if (tracked_zone != ZONE_CLEAR) begin
         front_hit = region_blocks(f.front, zone_cfg.front_exit);
         left_hit  = region_blocks(f.left, zone_cfg.left_exit);
         right_hit = region_blocks(f.right, zone_cfg.right_exit);
         if (front_hit || left_hit || right_hit) begin
            tracked_safe = 8'd0;
            if (front_hit)
               tracked_zone = ZONE_CORNER;
            else if (left_hit && !right_hit)
               tracked_zone = ZONE_LEFT;
            else if (right_hit && !left_hit)
               tracked_zone = ZONE_RIGHT;
            else
               tracked_zone = (f.left.depth <= f.right.depth) ? ZONE_LEFT : ZONE_RIGHT;
         end else begin
            need = (zone_cfg.safe_needed == 8'd0) ? 8'd1 : zone_cfg.safe_needed;
            if (tracked_safe != 8'hFF)
               tracked_safe++;
            if (tracked_safe >= need) begin
               tracked_zone = ZONE_CLEAR;
               tracked_safe = 8'd0;
            end
         end
      end else begin
         if (region_blocks(f.front, zone_cfg.front_enter)) begin
            tracked_zone = ZONE_CORNER;
            tracked_safe = 8'd0;
         end else if (region_blocks(f.left, zone_cfg.left_enter)) begin
            tracked_zone = ZONE_LEFT;
            tracked_safe = 8'd0;
         end else if (region_blocks(f.right, zone_cfg.right_enter)) begin
            tracked_zone = ZONE_RIGHT;
            tracked_safe = 8'd0;
         end
      end
      return tracked_zone;
   endfunction

   // Frame driver: one beat at a time, random gap after each beat
   always @(posedge clock) begin : frame_driver
      frame_type sent;
      frame_type nxt;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.front_depth <= '0;
         req_ch.front_near  <= '0;
         req_ch.front_valid <= '0;
         req_ch.left_depth  <= '0;
         req_ch.left_near   <= '0;
         req_ch.left_valid  <= '0;
         req_ch.right_depth <= '0;
         req_ch.right_near  <= '0;
         req_ch.right_valid <= '0;
         send_gap           <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sent.front = '{req_ch.front_depth, req_ch.front_near, req_ch.front_valid};
            sent.left  = '{req_ch.left_depth, req_ch.left_near, req_ch.left_valid};
            sent.right = '{req_ch.right_depth, req_ch.right_near, req_ch.right_valid};
            expected_zones = {expected_zones, next_zone(sent)};
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap     <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               nxt = pending_frames.pop_front();
               req_ch.front_depth <= nxt.front.depth;
               req_ch.front_near  <= nxt.front.near_px;
               req_ch.front_valid <= nxt.front.valid_px;
               req_ch.left_depth  <= nxt.left.depth;
               req_ch.left_near   <= nxt.left.near_px;
               req_ch.left_valid  <= nxt.left.valid_px;
               req_ch.right_depth <= nxt.right.depth;
               req_ch.right_near  <= nxt.right.near_px;
               req_ch.right_valid <= nxt.right.valid_px;
               req_ch.valid       <= 1'b1;
               send_gap           <= draw_wait(src_run, src_quiet);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Zone monitor: compare each beat with the oldest expectation, stall ready at random
   always @(posedge clock) begin : zone_monitor
      zone_code_type want;
      int            stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_wait    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_zones.size() == 0) begin
            report_mismatch($sformatf("zone %0d with no frame outstanding", rsp_ch.zone));
         end else begin
            want = expected_zones.pop_front();
            frames_in_flight--;
            if (rsp_ch.zone !== want)
               report_mismatch($sformatf("got %0d, expected %0d", rsp_ch.zone, want));
         end
         stall = draw_wait(sink_run, sink_quiet);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            sink_wait    <= stall - 1;
         end
      end else if (!rsp_ch.ready) begin
         if (sink_wait == 0)
            rsp_ch.ready <= 1'b1;
         else
            sink_wait <= sink_wait - 1;
      end
   end

   function automatic region_type rgn(int depth, int near_px, int valid_px);
      region_type r;
      r.depth    = 16'(depth);
      r.near_px  = 16'(near_px);
      r.valid_px = 16'(valid_px);
      return r;
   endfunction

   function automatic logic [15:0] highest(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      logic [15:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // Region that blocks against limit when want_hit and limit is above one, else one that never blocks against it
   function automatic region_type make_region(logic [15:0] limit, bit want_hit);
      region_type r;
      r.depth    = 16'($urandom);
      r.near_px  = 16'($urandom);
      r.valid_px = 16'($urandom);
      if (want_hit && limit > 16'd1) begin
         case ($urandom_range(0, 3))
            0:       r.depth = limit - 16'd1;
            1:       r.depth = 16'd1;
            default: r.depth = 16'($urandom_range(1, limit - 1));
         endcase
         r.near_px  = ($urandom_range(0, 3) == 0) ? NEAR_COUNT_MIN :
                      16'($urandom_range(NEAR_COUNT_MIN, 16'hFFFF));
         r.valid_px = ($urandom_range(0, 3) == 0) ? VALID_PIXEL_MIN :
                      16'($urandom_range(VALID_PIXEL_MIN, 16'hFFFF));
      end else if (!want_hit) begin
         case ($urandom_range(0, 9))
            0, 1:    r.depth = 16'd0;
            2, 3, 4: r.depth = ($urandom_range(0, 1) == 0) ? limit :
                               16'($urandom_range(limit, 16'hFFFF));
            5, 6:    r.near_px = 16'($urandom_range(0, NEAR_COUNT_MIN - 1));
            7, 8:    r.valid_px = 16'($urandom_range(0, VALID_PIXEL_MIN - 1));
            default: ;
         endcase
         if (region_blocks(r, limit))
            r.depth = 16'd0;
      end
      return r;
   endfunction

   function automatic frame_type make_frame(bit hit_f, bit hit_l, bit hit_r);
      frame_type   f;
      logic [15:0] f_lim;
      logic [15:0] l_lim;
      logic [15:0] r_lim;
      case ($urandom_range(0, 2))
         0:       f_lim = zone_cfg.front_enter;
         1:       f_lim = zone_cfg.front_exit;
         default: f_lim = zone_cfg.emergency;
      endcase
      l_lim = $urandom_range(0, 1) ? zone_cfg.left_enter : zone_cfg.left_exit;
      r_lim = $urandom_range(0, 1) ? zone_cfg.right_enter : zone_cfg.right_exit;
      if (!hit_f)
         f_lim = highest(zone_cfg.front_enter, zone_cfg.front_exit, zone_cfg.emergency);
      if (!hit_l)
         l_lim = highest(zone_cfg.left_enter, zone_cfg.left_exit, zone_cfg.left_exit);
      if (!hit_r)
         r_lim = highest(zone_cfg.right_enter, zone_cfg.right_exit, zone_cfg.right_exit);
      f.front = make_region(f_lim, hit_f);
      f.left  = make_region(l_lim, hit_l);
      f.right = make_region(r_lim, hit_r);
      // Equal side depths now and then, to exercise the tie rule
      if (hit_l && hit_r && $urandom_range(0, 2) == 0 && f.left.depth < r_lim)
         f.right.depth = f.left.depth;
      return f;
   endfunction

   task automatic queue_frame(frame_type f);
      pending_frames = {pending_frames, f};
      frames_in_flight++;
   endtask

   task automatic wait_idle();
      while (frames_in_flight != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_FRONT_ENTER: zone_cfg.front_enter = value;
         CSR_FRONT_EXIT:  zone_cfg.front_exit  = value;
         CSR_EMERGENCY:   zone_cfg.emergency   = value;
         CSR_LEFT_ENTER:  zone_cfg.left_enter  = value;
         CSR_LEFT_EXIT:   zone_cfg.left_exit   = value;
         CSR_RIGHT_ENTER: zone_cfg.right_enter = value;
         CSR_RIGHT_EXIT:  zone_cfg.right_exit  = value;
         CSR_SAFE_NEEDED: zone_cfg.safe_needed = value[7:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(logic [15:0] fe, logic [15:0] fx, logic [15:0] em,
                               logic [15:0] le, logic [15:0] lx, logic [15:0] re,
                               logic [15:0] rx, logic [15:0] safe_word);
      wait_idle();
      write_reg(CSR_FRONT_ENTER, fe);
      write_reg(CSR_FRONT_EXIT, fx);
      write_reg(CSR_EMERGENCY, em);
      write_reg(CSR_LEFT_ENTER, le);
      write_reg(CSR_LEFT_EXIT, lx);
      write_reg(CSR_RIGHT_ENTER, re);
      write_reg(CSR_RIGHT_EXIT, rx);
      write_reg(CSR_SAFE_NEEDED, safe_word);
   endtask

   // Episodes: a short obstacle burst, then a run of safe frames near the return count
   task automatic run_phase(int count);
      int           made;
      int           burst;
      int           quiet_len;
      int           need;
      bit           hf;
      bit           hl;
      bit           hr;
      logic [159:0] noise;
      made = 0;
      need = (zone_cfg.safe_needed == 8'd0) ? 1 : zone_cfg.safe_needed;
      if (need > 12)
         need = 12;
      while (made < count) begin
         burst = $urandom_range(1, 4);
         for (int k = 0; k < burst; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
               queue_frame(noise[143:0]);
            end else begin
               hf = $urandom_range(0, 1);
               hl = $urandom_range(0, 1);
               hr = $urandom_range(0, 1);
               if (!hf && !hl && !hr)
                  hl = 1'b1;
               queue_frame(make_frame(hf, hl, hr));
            end
            made++;
         end
         quiet_len = $urandom_range(0, need + 2);
         for (int k = 0; k < quiet_len; k++) begin
            queue_frame(make_frame(1'b0, 1'b0, 1'b0));
            made++;
         end
      end
   endtask

   // Stimulus: directed frames at reset settings, then register phases with random frames
   initial begin
      region_type none;
      region_type far;
      reset        = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_FRONT_ENTER;
      csr_ch.data  = '0;
      zone_cfg = '{RST_ENTER_MM, RST_EXIT_MM, RST_EMERGENCY_MM, RST_ENTER_MM,
                   RST_EXIT_MM, RST_ENTER_MM, RST_EXIT_MM, RST_SAFE_NEEDED};
      tracked_zone = ZONE_CLEAR;
      tracked_safe = 8'd0;
      none = rgn(0, 0, 0);
      far  = rgn(65535, 65535, 65535);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty frame, then a left obstacle at the pixel count minimums
      queue_frame('{none, none, none});
      queue_frame('{none, rgn(599, 4, 60), none});
      // Left held by the exit threshold, then safe frames just under the minimums and one of zero depth
      queue_frame('{none, rgn(799, 4, 60), none});
      queue_frame('{none, rgn(500, 3, 60), none});
      queue_frame('{none, rgn(500, 4, 59), none});
      queue_frame('{none, rgn(0, 65535, 65535), none});
      // Emergency, then corner held by the front exit threshold
      queue_frame('{rgn(299, 4, 60), none, none});
      queue_frame('{rgn(799, 65535, 65535), none, none});
      // Both sides near: equal depths go left, otherwise the nearer side
      queue_frame('{rgn(800, 60, 60), rgn(700, 9, 99), rgn(700, 9, 99)});
      queue_frame('{rgn(800, 60, 60), rgn(750, 9, 99), rgn(650, 9, 99)});
      // Five far frames return to clear on the last one
      repeat (5) queue_frame('{far, far, far});
      // Emergency from clear with the smallest depth
      queue_frame('{rgn(1, 65535, 65535), none, none});
      queue_frame('{far, rgn(1, 4, 60), rgn(1, 4, 60)});
      queue_frame('{far, none, rgn(1, 4, 60)});
      queue_frame('{rgn(600, 4, 60), none, none});

      program_regs(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                   16'($urandom_range(1, 1500)), 16'($urandom_range(1, 3000)),
                   16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                   16'($urandom_range(1, 3000)), 16'd3);
      run_phase(60);

      // Zero thresholds: no test can fire
      program_regs('0, '0, '0, '0, '0, '0, '0, 16'h0001);
      run_phase(30);

      // Full-scale thresholds; upper byte of the safe count write is dropped
      program_regs('1, '1, '1, '1, '1, '1, '1, 16'hFF02);
      run_phase(50);

      // Safe count of zero acts as one
      program_regs(16'd1000, 16'd1200, 16'd400, 16'd900, 16'd1300, 16'd700, 16'd1100,
                   16'hAB00);
      run_phase(70);

      // Largest safe count: a long safe run to get back to clear
      program_regs(16'd600, 16'd800, 16'd300, 16'd600, 16'd800, 16'd600, 16'd800, 16'h00FF);
      repeat (4) queue_frame(make_frame(1'b0, 1'b1, 1'b1));
      repeat (258) queue_frame(make_frame(1'b0, 1'b0, 1'b0));
      run_phase(20);

      // Enter thresholds above exit, emergency above front
      program_regs(16'd5000, 16'd500, 16'd8000, 16'd4000, 16'd300, 16'd4500, 16'd350, 16'd4);
      run_phase(60);

      program_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2000)),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(1, 8)));
      run_phase(80);

      // Drain, then give any stray beat time to show up
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
